/* hw/rtl/arc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_pkg: shared types and constants of the authorization record checker
// Record layout, CRC constants, verdict codes and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package arc_pkg;

   localparam int RECORD_BYTES = 32;
   localparam int POS_W        = $clog2(RECORD_BYTES);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   localparam logic [POS_W-1:0] POS_FIRST    = POS_W'(0);
   localparam logic [POS_W-1:0] POS_VERSION  = POS_W'(4);
   localparam logic [POS_W-1:0] POS_STATE    = POS_W'(5);
   localparam logic [POS_W-1:0] POS_GEN      = POS_W'(8);
   localparam logic [POS_W-1:0] POS_OWN_HIGH = POS_W'(12);
   localparam logic [POS_W-1:0] POS_OWN_LOW  = POS_W'(20);
   localparam logic [POS_W-1:0] POS_CRC      = POS_W'(28);
   localparam logic [POS_W-1:0] POS_LAST     = POS_W'(RECORD_BYTES - 1);

   localparam logic [7:0] MAGIC_0 = 8'h4F;
   localparam logic [7:0] MAGIC_1 = 8'h41;
   localparam logic [7:0] MAGIC_2 = 8'h50;
   localparam logic [7:0] MAGIC_3 = 8'h30;

   localparam logic [7:0] STATE_UNOWNED = 8'd0;
   localparam logic [7:0] STATE_OWNED   = 8'd1;

   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_BAD_MAGIC    = 3'd1;
   localparam logic [2:0] STATUS_BAD_VERSION  = 3'd2;
   localparam logic [2:0] STATUS_INVALID      = 3'd3;
   localparam logic [2:0] STATUS_CRC_MISMATCH = 3'd4;

   typedef struct packed {
      logic [7:0]       data_byte;
      logic [POS_W-1:0] pos;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
      logic [31:0] c;
      c = acc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

   function automatic logic [7:0] magic_at(input logic [1:0] idx);
      logic [7:0] m;
      case (idx)
         2'd0:    m = MAGIC_0;
         2'd1:    m = MAGIC_1;
         2'd2:    m = MAGIC_2;
         default: m = MAGIC_3;
      endcase
      return m;
   endfunction

endpackage

/* hw/rtl/arc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_if: channel interfaces of the authorization record checker
// Byte request channel and verdict response channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface arc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface arc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        is_owned;
   logic [31:0] generation;
   logic [63:0] owner_high;
   logic [63:0] owner_low;

   modport source (output valid, output status, output is_owned, output generation,
                   output owner_high, output owner_low, input ready);
   modport sink   (input valid, input status, input is_owned, input generation,
                   input owner_high, input owner_low, output ready);
endinterface

/* hw/rtl/arc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_front: byte intake
// Accepts record bytes, tracks the byte position and tags each item with it.
// ----------------------------------------------------------------------------
module arc_front import arc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   arc_req_if.sink           req_ch,
   input  q_stat_type        q_stat,
   output logic              push,
   output q_entry_type       push_entry
);

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] cur_pos;

   assign req_ch.ready = !q_stat.full;
   assign push         = req_ch.valid && !q_stat.full;
   assign cur_pos      = req_ch.frame_start ? POS_FIRST : pos_ff;

   assign push_entry.data_byte = req_ch.data_byte;
   assign push_entry.pos       = cur_pos;

   // position wraps from the last byte back to zero
   assign pos_in = push ? cur_pos + POS_W'(1) : pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_FIRST;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

/* hw/rtl/arc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_queue: front-to-back item queue
// Small register queue that decouples byte intake from record processing.
// ----------------------------------------------------------------------------
module arc_queue import arc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_entry,
   input  logic        pop,
   output q_entry_type head,
   output q_stat_type  q_stat
);

   q_entry_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == QCNT_W'(0));
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hw/rtl/arc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_back: record processing and verdict
// Runs the CRC, captures fields and registers one verdict per complete record.
// ----------------------------------------------------------------------------
module arc_back import arc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  q_entry_type head,
   input  q_stat_type  q_stat,
   output logic        pop,
   arc_rsp_if.source   rsp_ch
);

   logic [31:0] crc_ff,  crc_in;
   logic        magic_bad_ff, magic_bad_in;
   logic        ver_bad_ff, ver_bad_in;
   logic        rsv_bad_ff, rsv_bad_in;
   logic [7:0]  state_ff, state_in;
   logic [31:0] gen_ff, gen_in;
   logic [63:0] ohi_ff, ohi_in;
   logic [63:0] olo_ff, olo_in;
   logic [31:0] scrc_ff, scrc_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff, status_in;
   logic        owned_ff, owned_in;
   logic [31:0] rgen_ff, rgen_in;
   logic [63:0] rhi_ff, rhi_in;
   logic [63:0] rlo_ff, rlo_in;

   logic [7:0]       b;
   logic [POS_W-1:0] pos;
   logic [POS_W-1:0] ohi_off;
   logic [POS_W-1:0] olo_off;
   logic             first;
   logic             owner_nz;
   logic             rec_valid;
   logic             crc_ok;

   assign pop     = !q_stat.empty && (!rsp_valid_ff || rsp_ch.ready);
   assign b       = head.data_byte;
   assign pos     = head.pos;
   assign first   = (pos == POS_FIRST);
   assign ohi_off = pos - POS_OWN_HIGH;
   assign olo_off = pos - POS_OWN_LOW;

   always_comb begin
      // a record restarts from the preset state at byte zero
      crc_in       = first ? CRC_INIT : crc_ff;
      magic_bad_in = first ? 1'b0 : magic_bad_ff;
      ver_bad_in   = first ? 1'b0 : ver_bad_ff;
      rsv_bad_in   = first ? 1'b0 : rsv_bad_ff;
      state_in     = first ? 8'd0 : state_ff;
      gen_in       = first ? 32'd0 : gen_ff;
      ohi_in       = first ? 64'd0 : ohi_ff;
      olo_in       = first ? 64'd0 : olo_ff;
      scrc_in      = first ? 32'd0 : scrc_ff;

      if (pos < POS_CRC) begin
         crc_in = crc_byte(crc_in, b);
      end

      case (pos) inside
         [POS_FIRST:POS_W'(3)]: begin
            if (b != magic_at(pos[1:0])) magic_bad_in = 1'b1;
         end
         POS_VERSION: begin
            if (b != 8'd0) ver_bad_in = 1'b1;
         end
         POS_STATE: begin
            state_in = b;
         end
         [POS_W'(6):POS_W'(7)]: begin
            if (b != 8'd0) rsv_bad_in = 1'b1;
         end
         [POS_GEN:POS_W'(11)]: begin
            gen_in[8*pos[1:0] +: 8] = b;
         end
         [POS_OWN_HIGH:POS_W'(19)]: begin
            ohi_in[8*ohi_off[2:0] +: 8] = b;
         end
         [POS_OWN_LOW:POS_W'(27)]: begin
            olo_in[8*olo_off[2:0] +: 8] = b;
         end
         default: begin
            scrc_in[8*pos[1:0] +: 8] = b;
         end
      endcase

      owner_nz  = (|ohi_in) || (|olo_in);
      rec_valid = (|gen_in) &&
                  ((state_in == STATE_UNOWNED && !owner_nz) ||
                   (state_in == STATE_OWNED && owner_nz));
      crc_ok    = (scrc_in == ~crc_in);

      if (magic_bad_in) begin
         status_in = STATUS_BAD_MAGIC;
      end else if (ver_bad_in) begin
         status_in = STATUS_BAD_VERSION;
      end else if (rsv_bad_in) begin
         status_in = STATUS_INVALID;
      end else if (!crc_ok) begin
         status_in = STATUS_CRC_MISMATCH;
      end else if (!rec_valid) begin
         status_in = STATUS_INVALID;
      end else begin
         status_in = STATUS_OK;
      end

      if (status_in == STATUS_OK) begin
         owned_in = (state_in == STATE_OWNED);
         rgen_in  = gen_in;
         rhi_in   = ohi_in;
         rlo_in   = olo_in;
      end else begin
         owned_in = 1'b0;
         rgen_in  = 32'd0;
         rhi_in   = 64'd0;
         rlo_in   = 64'd0;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (pop && pos == POS_LAST) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         crc_ff       <= crc_in;
         magic_bad_ff <= magic_bad_in;
         ver_bad_ff   <= ver_bad_in;
         rsv_bad_ff   <= rsv_bad_in;
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         ohi_ff       <= ohi_in;
         olo_ff       <= olo_in;
         scrc_ff      <= scrc_in;
      end
      if (pop && pos == POS_LAST) begin
         status_ff <= status_in;
         owned_ff  <= owned_in;
         rgen_ff   <= rgen_in;
         rhi_ff    <= rhi_in;
         rlo_ff    <= rlo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.is_owned   = owned_ff;
   assign rsp_ch.generation = rgen_ff;
   assign rsp_ch.owner_high = rhi_ff;
   assign rsp_ch.owner_low  = rlo_ff;

endmodule

/* hw/rtl/auth_record_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auth_record_checker: stored authorization record checker
// Validates 32-byte records streamed one byte per item and issues a verdict.
// ----------------------------------------------------------------------------
// usage
//   req_ch carries one record byte per item; frame_start marks byte zero and
//   drops any partial record. Without it the position simply counts 0..31.
//   rsp_ch carries one verdict per record: status, and when status is ok the
//   owned flag, generation and owner words (all zero otherwise).
// timing
//   one byte per cycle sustained while no verdict is held. Accepted bytes wait
//   in a four-item queue; the back end takes one per cycle unless stalled, the
//   CRC byte update being its longest path. The last byte is written to the
//   queue, then popped by the back end, which registers the verdict.
// reset
//   synchronous; clears the position, the queue and the verdict valid flag.
// backpressure
//   a held verdict stalls the back end only; intake keeps going until the
//   queue fills, then req_ch.ready drops.
// ----------------------------------------------------------------------------
module auth_record_checker import arc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   arc_req_if.sink   req_ch,
   arc_rsp_if.source rsp_ch
);

   logic        push;
   logic        pop;
   q_entry_type push_entry;
   q_entry_type head;
   q_stat_type  q_stat;

   arc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   arc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   arc_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
